>>> hdl/oahm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package oahm_pkg;

	localparam int DEFAULT_MAX_SLOTS = 1024;

	localparam int KEY_W        = 64;
	localparam int VAL_W        = 32;
	localparam int STATUS_W     = 3;
	localparam int TABLE_SIZE_W = 11;
	localparam int STEP_W       = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int BIT_CNT_W    = $clog2(KEY_W);

	localparam logic [TABLE_SIZE_W-1:0] RESET_TABLE_SIZE = TABLE_SIZE_W'(1024);
	localparam logic [STEP_W-1:0]       RESET_PROBE_STEP = STEP_W'(7919);
	localparam logic [VAL_W-1:0]        NEG_ONE          = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PROBE_STEP = CFG_IDX_W'(1);

	// request modes
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_FIND   = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_INSERTED = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] STAT_PRESENT  = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] STAT_HIT      = STATUS_W'(2);
	localparam logic [STATUS_W-1:0] STAT_MISS     = STATUS_W'(3);
	localparam logic [STATUS_W-1:0] STAT_FULL     = STATUS_W'(4);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD_STEP,
		S_MOD_KEY,
		S_READ,
		S_CHECK,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_t;

endpackage

`default_nettype wire

>>> hdl/open_addressing_hash_map.sv
`timescale 1ns / 1ps
`default_nettype none

// Open-addressing key/value table with fixed-step probing. A request is an
// insert-if-absent (mode 0) or a find (mode 1) on a 64-bit key; every request
// gives exactly one response with result_value and status (0 inserted,
// 1 already present, 2 find hit, 3 find miss, 4 table full). The home slot is
// key mod size and each collision adds probe_step mod size. One request is in
// work at a time: it is accepted, probe_step is reduced mod size and then the
// key mod size (both on one shift/subtract unit), then each probed slot is a
// registered memory read followed by a compare, and the result is handed off
// to the response register; probes lie between 1 and size. After reset the
// slot memory is cleared one entry a cycle, during which req_stall stays high;
// configuration writes are taken at any time but should only be issued while
// no request is in work.
module open_addressing_hash_map #(
	parameter int MAX_SLOTS = oahm_pkg::DEFAULT_MAX_SLOTS
) (
	input  wire                                   clk,
	input  wire                                   arst_n,

	// request channel
	input  wire                                   req_valid,
	output logic                                  req_stall,
	input  wire                                   mode,
	input  wire        [oahm_pkg::KEY_W-1:0]      key,
	input  wire signed [oahm_pkg::VAL_W-1:0]      value,

	// response channel
	output logic                                  rsp_valid,
	input  wire                                   rsp_stall,
	output logic signed [oahm_pkg::VAL_W-1:0]     result_value,
	output logic       [oahm_pkg::STATUS_W-1:0]   status,

	// configuration write channel
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire        [oahm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire        [oahm_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(MAX_SLOTS);
	// wide enough to hold MAX_SLOTS itself
	localparam int SZ_W  = $clog2(MAX_SLOTS + 1);
	localparam int SUM_W = SZ_W + 1;

	localparam int KEY_W  = oahm_pkg::KEY_W;
	localparam int VAL_W  = oahm_pkg::VAL_W;
	localparam int STEP_W = oahm_pkg::STEP_W;
	localparam int BCW    = oahm_pkg::BIT_CNT_W;

	// configuration registers
	logic [oahm_pkg::TABLE_SIZE_W-1:0] cfg_size_q;
	logic [STEP_W-1:0]                 cfg_step_q;

	// sequencer
	oahm_pkg::state_t state_q, state_d;

	// request context
	logic              mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  value_q;
	logic [SZ_W-1:0]   size_q;

	// shared shift/subtract modulo unit
	logic [KEY_W-1:0]  div_q;
	logic [SZ_W-1:0]   rem_q;
	logic [BCW-1:0]    bit_cnt_q;
	logic [SZ_W:0]     trial;
	logic [SZ_W:0]     trial_red;
	logic [SZ_W-1:0]   rem_next;

	// probing
	logic [IDX_W-1:0]  step_mod_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SZ_W-1:0]   probe_cnt_q;
	logic [SZ_W-1:0]   probe_cnt_inc;
	logic [SUM_W-1:0]  idx_sum;
	logic [IDX_W-1:0]  idx_next;
	logic              key_match;

	// clearing pass
	logic [IDX_W-1:0]  clr_q;
	logic              clr_last;

	// slot memory
	oahm_pkg::slot_t   mem [MAX_SLOTS];
	oahm_pkg::slot_t   rd_q;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	oahm_pkg::slot_t   mem_wdata;

	// result staging
	logic [VAL_W-1:0]              res_q;
	logic [oahm_pkg::STATUS_W-1:0] stat_q;

	logic              req_xfer;
	logic              rsp_xfer;
	logic              rsp_free;
	logic [SZ_W-1:0]   eff_size;

	assign req_xfer  = req_valid && !req_stall;
	assign rsp_xfer  = rsp_valid && !rsp_stall;
	assign rsp_free  = !rsp_valid || !rsp_stall;
	assign cfg_ready = 1'b1;

	// size zero acts as one, sizes above the memory depth saturate
	always_comb begin
		if (cfg_size_q == '0) begin
			eff_size = SZ_W'(1);
		end else if (32'(cfg_size_q) > 32'(MAX_SLOTS)) begin
			eff_size = SZ_W'(MAX_SLOTS);
		end else begin
			eff_size = SZ_W'(cfg_size_q);
		end
	end

	// one restoring step: bring in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, div_q[KEY_W-1]};
		if (trial >= {1'b0, size_q}) begin
			trial_red = trial - {1'b0, size_q};
		end else begin
			trial_red = trial;
		end
		rem_next = trial_red[SZ_W-1:0];
	end

	// next probe slot: both terms are below size, so one subtract suffices
	always_comb begin
		idx_sum = SUM_W'(idx_q) + SUM_W'(step_mod_q);
		if (idx_sum >= SUM_W'(size_q)) begin
			idx_next = IDX_W'(idx_sum - SUM_W'(size_q));
		end else begin
			idx_next = IDX_W'(idx_sum);
		end
	end

	assign probe_cnt_inc = probe_cnt_q + SZ_W'(1);
	assign key_match     = rd_q.key == key_q;
	assign clr_last      = clr_q == IDX_W'(MAX_SLOTS - 1);

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_size_q <= oahm_pkg::RESET_TABLE_SIZE;
			cfg_step_q <= oahm_pkg::RESET_PROBE_STEP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				oahm_pkg::CFG_TABLE_SIZE: begin
					cfg_size_q <= cfg_data[oahm_pkg::TABLE_SIZE_W-1:0];
				end
				oahm_pkg::CFG_PROBE_STEP: begin
					cfg_step_q <= cfg_data[STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			oahm_pkg::S_CLEAR: begin
				if (clr_last) state_d = oahm_pkg::S_IDLE;
			end
			oahm_pkg::S_IDLE: begin
				if (req_xfer) state_d = oahm_pkg::S_MOD_STEP;
			end
			oahm_pkg::S_MOD_STEP: begin
				if (bit_cnt_q == '0) state_d = oahm_pkg::S_MOD_KEY;
			end
			oahm_pkg::S_MOD_KEY: begin
				if (bit_cnt_q == '0) state_d = oahm_pkg::S_READ;
			end
			oahm_pkg::S_READ: begin
				state_d = oahm_pkg::S_CHECK;
			end
			oahm_pkg::S_CHECK: begin
				if (!rd_q.valid || key_match || probe_cnt_inc == size_q) begin
					state_d = oahm_pkg::S_FINISH;
				end else begin
					state_d = oahm_pkg::S_READ;
				end
			end
			oahm_pkg::S_FINISH: begin
				if (rsp_free) state_d = oahm_pkg::S_IDLE;
			end
			default: begin
				state_d = oahm_pkg::S_IDLE;
			end
		endcase
	end

	// sequencer outputs: request stall and the memory write port
	always_comb begin
		req_stall = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '{valid: 1'b1, key: key_q, value: value_q};
		case (state_q)
			oahm_pkg::S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			oahm_pkg::S_IDLE: begin
				req_stall = 1'b0;
			end
			oahm_pkg::S_CHECK: begin
				// empty slot on insert: claim it
				mem_we = !rd_q.valid && mode_q == oahm_pkg::MODE_INSERT;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oahm_pkg::S_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == oahm_pkg::S_CLEAR) clr_q <= clr_q + IDX_W'(1);
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		case (state_q)
			oahm_pkg::S_IDLE: begin
				mode_q    <= mode;
				key_q     <= key;
				value_q   <= value;
				size_q    <= eff_size;
				// reduce the step first: its 16 bits sit at the top of the shifter
				div_q     <= {cfg_step_q, (KEY_W - STEP_W)'(0)};
				rem_q     <= '0;
				bit_cnt_q <= BCW'(STEP_W - 1);
			end
			oahm_pkg::S_MOD_STEP: begin
				if (bit_cnt_q == '0) begin
					step_mod_q <= IDX_W'(rem_next);
					div_q      <= key_q;
					rem_q      <= '0;
					bit_cnt_q  <= BCW'(KEY_W - 1);
				end else begin
					div_q     <= div_q << 1;
					rem_q     <= rem_next;
					bit_cnt_q <= bit_cnt_q - BCW'(1);
				end
			end
			oahm_pkg::S_MOD_KEY: begin
				div_q     <= div_q << 1;
				rem_q     <= rem_next;
				bit_cnt_q <= bit_cnt_q - BCW'(1);
				if (bit_cnt_q == '0) begin
					idx_q       <= IDX_W'(rem_next);
					probe_cnt_q <= '0;
				end
			end
			oahm_pkg::S_CHECK: begin
				idx_q       <= idx_next;
				probe_cnt_q <= probe_cnt_inc;
				if (!rd_q.valid) begin
					if (mode_q == oahm_pkg::MODE_INSERT) begin
						res_q  <= value_q;
						stat_q <= oahm_pkg::STAT_INSERTED;
					end else begin
						res_q  <= oahm_pkg::NEG_ONE;
						stat_q <= oahm_pkg::STAT_MISS;
					end
				end else if (key_match) begin
					res_q  <= rd_q.value;
					stat_q <= (mode_q == oahm_pkg::MODE_INSERT) ?
						oahm_pkg::STAT_PRESENT : oahm_pkg::STAT_HIT;
				end else begin
					// every visit exhausted without a free slot or a match
					res_q  <= oahm_pkg::NEG_ONE;
					stat_q <= oahm_pkg::STAT_FULL;
				end
			end
			default: begin
			end
		endcase
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[idx_q];
	end

	// response register, parts the sequencer from the response stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (state_q == oahm_pkg::S_FINISH && rsp_free) begin
			rsp_valid <= 1'b1;
		end else if (rsp_xfer) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == oahm_pkg::S_FINISH && rsp_free) begin
			result_value <= res_q;
			status       <= stat_q;
		end
	end

endmodule

`default_nettype wire
